>>> hdl/dsxe_pkg.sv
// Shared types, constants and the substitution table of the datagram encoder.
// No dependencies; imported by the controller, the datapath and the top level.
package dsxe_pkg;

    // Packet store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FRAME_BYTES = 4092;
    localparam int PAYLOAD_MAX = FRAME_BYTES - 1;
    localparam int CAPACITY    = (STORE_DEPTH < PAYLOAD_MAX) ? STORE_DEPTH : PAYLOAD_MAX;
    localparam int CNT_W       = 13;

    // Mixing constants
    localparam logic [7:0] CHECK_MASK = 8'hAA;
    localparam logic [7:0] KEY_MIX    = 8'hCC;

    // Item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] plain_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_byte;
        logic       overflow;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load;
        logic emit;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_READ,
        S_EMIT
    } t_state;

    // Fixed byte substitution table
    localparam logic [7:0] SUB_ROM [0:255] = '{
        8'h27, 8'h69, 8'hFD, 8'h87, 8'h60, 8'h7D, 8'h83, 8'h02,
        8'hF2, 8'h3F, 8'h71, 8'h99, 8'hA3, 8'h7C, 8'h1B, 8'h9D,
        8'h76, 8'h30, 8'h23, 8'h25, 8'hC5, 8'h82, 8'h9B, 8'hEB,
        8'h1E, 8'hFA, 8'h46, 8'h4F, 8'h98, 8'hC9, 8'h37, 8'h88,
        8'h18, 8'hA2, 8'h68, 8'hD6, 8'hD7, 8'h22, 8'hD1, 8'h74,
        8'h7A, 8'h79, 8'h2E, 8'hD2, 8'h6D, 8'h48, 8'h0F, 8'hB1,
        8'h62, 8'h97, 8'hBC, 8'h8B, 8'h59, 8'h7F, 8'h29, 8'hB6,
        8'hB9, 8'h61, 8'hBE, 8'hC8, 8'hC1, 8'hC6, 8'h40, 8'hEF,
        8'h11, 8'h6A, 8'hA5, 8'hC7, 8'h3A, 8'hF4, 8'h4C, 8'h13,
        8'h6C, 8'h2B, 8'h1C, 8'h54, 8'h56, 8'h55, 8'h53, 8'hA8,
        8'hDC, 8'h9C, 8'h9A, 8'h16, 8'hDD, 8'hB0, 8'hF5, 8'h2D,
        8'hFF, 8'hDE, 8'h8A, 8'h90, 8'hFC, 8'h95, 8'hEC, 8'h31,
        8'h85, 8'hC2, 8'h01, 8'h06, 8'hDB, 8'h28, 8'hD8, 8'hEA,
        8'hA0, 8'hDA, 8'h10, 8'h0E, 8'hF0, 8'h2A, 8'h6B, 8'h21,
        8'hF1, 8'h86, 8'hFB, 8'h65, 8'hE1, 8'h6F, 8'hF6, 8'h26,
        8'h33, 8'h39, 8'hAE, 8'hBF, 8'hD4, 8'hE4, 8'hE9, 8'h44,
        8'h75, 8'h3D, 8'h63, 8'hBD, 8'hC0, 8'h7B, 8'h9E, 8'hA6,
        8'h5C, 8'h1F, 8'hB2, 8'hA4, 8'hC4, 8'h8D, 8'hB3, 8'hFE,
        8'h8F, 8'h19, 8'h8C, 8'h4D, 8'h5E, 8'h34, 8'hCC, 8'hF9,
        8'hB5, 8'hF3, 8'hF8, 8'hA1, 8'h50, 8'h04, 8'h93, 8'h73,
        8'hE0, 8'hBA, 8'hCB, 8'h45, 8'h35, 8'h1A, 8'h49, 8'h47,
        8'h6E, 8'h2F, 8'h51, 8'h12, 8'hE2, 8'h4A, 8'h72, 8'h05,
        8'h66, 8'h70, 8'hB8, 8'hCD, 8'h00, 8'hE5, 8'hBB, 8'h24,
        8'h58, 8'hEE, 8'hB4, 8'h80, 8'h81, 8'h36, 8'hA9, 8'h67,
        8'h5A, 8'h4B, 8'hE8, 8'hCA, 8'hCF, 8'h9F, 8'hE3, 8'hAC,
        8'hAA, 8'h14, 8'h5B, 8'h5F, 8'h0A, 8'h3B, 8'h77, 8'h92,
        8'h09, 8'h15, 8'h4E, 8'h94, 8'hAD, 8'h17, 8'h64, 8'h52,
        8'hD3, 8'h38, 8'h43, 8'h0D, 8'h0C, 8'h07, 8'h3C, 8'h1D,
        8'hAF, 8'hED, 8'hE7, 8'h08, 8'hB7, 8'h03, 8'hE6, 8'h8E,
        8'hAB, 8'h91, 8'h89, 8'h3E, 8'h2C, 8'h96, 8'h42, 8'hD9,
        8'h78, 8'hDF, 8'hD0, 8'h57, 8'h5D, 8'h84, 8'h41, 8'h7E,
        8'hCE, 8'hF7, 8'h32, 8'hC3, 8'hD5, 8'h20, 8'h0B, 8'hA7
    };

endpackage

>>> hdl/dsxe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsxe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dsxe_ctrl.sv
// Controller state machine: sequences load and drain items, issues commands.
// Depends on dsxe_pkg.
module dsxe_ctrl
    import dsxe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_mode,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_mode == MODE_DRAIN) ? S_READ : S_LOAD;
                end
            end
            S_LOAD:  n_state = S_IDLE;
            S_READ:  n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_busy        = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.emit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            S_LOAD:  o_cmd.load = 1'b1;
            S_READ:  o_busy = 1'b1;  // store read in flight
            S_EMIT:  o_cmd.emit = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

>>> hdl/dsxe_datapath.sv
// Datapath: item register, checksum, parity, counters, key and packet store.
// Depends on dsxe_pkg and dsxe_ram.
module dsxe_datapath
    import dsxe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_item   i_in_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output t_out_item  o_out_item
);

    t_in_item          r_item;
    logic [7:0]        r_key;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  r_read_pos;
    logic [CNT_W-1:0]  n_read_pos;
    logic [7:0]        r_check;
    logic [7:0]        n_check;
    logic              r_odd;
    logic              n_odd;
    logic              r_dropped;
    logic              n_dropped;

    logic              w_drop;
    logic              w_we;
    logic [7:0]        w_wdata;
    logic [CNT_W-1:0]  w_rd_pos;
    logic [7:0]        w_rdata;
    logic              w_at_check;
    logic              w_last;

    // Captured item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    // Load path: drop test, substitution and key mix
    assign w_drop  = (r_read_pos != '0) || (r_fill >= CNT_W'(CAPACITY));
    assign w_we    = i_cmd.load && !w_drop;
    assign w_wdata = SUB_ROM[r_item.plain_byte] ^ (r_odd ? (r_key ^ KEY_MIX) : 8'h00);

    // Drain path: checksum first, then stored bytes
    assign w_rd_pos   = r_read_pos - CNT_W'(1);
    assign w_at_check = (r_read_pos == '0);
    assign w_last     = w_at_check ? (r_fill == '0) : (r_read_pos >= r_fill);

    dsxe_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_pos[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Datagram state next values
    always_comb begin
        n_fill     = r_fill;
        n_read_pos = r_read_pos;
        n_check    = r_check;
        n_odd      = r_odd;
        n_dropped  = r_dropped;
        if (i_cmd.load) begin
            if (w_drop) begin
                n_dropped = 1'b1;
            end else begin
                n_check = r_check ^ (r_item.plain_byte & CHECK_MASK);
                n_odd   = ~r_odd;
                n_fill  = r_fill + CNT_W'(1);
            end
        end else if (i_cmd.emit) begin
            if (w_last) begin
                n_fill     = '0;
                n_read_pos = '0;
                n_check    = '0;
                n_odd      = 1'b0;
                n_dropped  = 1'b0;
            end else begin
                n_read_pos = r_read_pos + CNT_W'(1);
            end
        end
    end

    // Datagram state and key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_fill     <= '0;
            r_read_pos <= '0;
            r_check    <= '0;
            r_odd      <= 1'b0;
            r_dropped  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_data;
            end
            r_fill     <= n_fill;
            r_read_pos <= n_read_pos;
            r_check    <= n_check;
            r_odd      <= n_odd;
            r_dropped  <= n_dropped;
        end
    end

    // Result item
    assign o_out_item.cipher_byte = w_at_check ? r_check : w_rdata;
    assign o_out_item.last_byte   = w_last;
    assign o_out_item.overflow    = r_dropped;

endmodule

>>> hdl/datagram_substitution_xor_encoder.sv
// Top level of the datagram substitution/XOR encoder.
// Depends on dsxe_pkg, dsxe_ctrl and dsxe_datapath.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------
//  input    | start, busy                   | i_in_item (t_in_item)
//  result   | o_result_valid (strobe)       | o_out_item (t_out_item)
//  config   | i_cfg_valid, o_cfg_ready      | i_cfg_data (port key)
//
// A load item is captured, then written to the store. A drain item is
// captured, then the store is read (registered RAM port), then the result is
// strobed. One item is in work at a time; busy covers it.
// Reset is synchronous and clears the datagram state and the key; the packet
// store is not cleared, entries are only read after they were written.
// The result strobe lasts one cycle and the receiver cannot stall it.
module datagram_substitution_xor_encoder
    import dsxe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_in_item,
    output logic       o_result_valid,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = w_cmd.emit;

    dsxe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_in_item.mode),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    dsxe_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

    // Accepted item always holds the block for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // Each result comes from a drain item accepted before the read and emit states
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy && (i_in_item.mode == MODE_DRAIN), 2))
        else $error("result without a matching drain item");

    // A result is never repeated in the following cycle
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // Load commands never produce a result in the same cycle
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !o_result_valid)
        else $error("result during a load");

endmodule
